// ===== rtl/gbfp_pkg.sv =====
package gbfp_pkg;

   typedef enum logic [1:0] {
      STATUS_BUSY     = 2'd0,
      STATUS_GOOD     = 2'd1,
      STATUS_BAD      = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   localparam logic [9:0] POS_AFTER_SYNC1 = 10'd1;
   localparam logic [9:0] POS_AFTER_SYNC2 = 10'd2;
   localparam logic [9:0] POS_AFTER_CLASS = 10'd3;
   localparam logic [9:0] POS_AFTER_ID    = 10'd4;
   localparam logic [9:0] POS_AFTER_LENLO = 10'd5;
   localparam logic [9:0] POS_AFTER_LENHI = 10'd6;

endpackage

// ===== rtl/gbfp_req_if.sv =====
interface gbfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/gbfp_rsp_if.sv =====
interface gbfp_rsp_if
   import gbfp_pkg::*;
   ();
   logic        valid;
   logic        ready;
   status_type  status;
   logic [7:0]  frame_class;
   logic [7:0]  frame_id;
   logic [15:0] frame_length;
   logic        payload_strobe;
   logic [7:0]  payload_byte;
   logic [9:0]  payload_index;

   modport source (output valid, output status, output frame_class, output frame_id,
                   output frame_length, output payload_strobe, output payload_byte,
                   output payload_index, input ready);
   modport sink   (input valid, input status, input frame_class, input frame_id,
                   input frame_length, input payload_strobe, input payload_byte,
                   input payload_index, output ready);
endinterface

// ===== rtl/gbfp_frame_parser.sv =====
module gbfp_frame_parser
   import gbfp_pkg::*;
#(
   parameter int MAX_FRAME = 1022
) (
   input logic        clock,
   input logic        reset,
   gbfp_req_if.sink   req_chan,
   gbfp_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {
      PH_HUNT1   = 4'd0,
      PH_HUNT2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LENLO   = 4'd4,
      PH_LENHI   = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CHKA    = 4'd7,
      PH_CHKB    = 4'd8
   } phase_type;

   localparam logic [10:0] MaxFrameW = 11'(MAX_FRAME);

   phase_type   phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [9:0]  position_ff, position_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  check_a_ff, check_a_in;

   logic        rsp_valid_ff;
   status_type  status_ff, status_in;
   logic [7:0]  out_class_ff;
   logic [7:0]  out_id_ff;
   logic [15:0] out_length_ff;
   logic        strobe_ff, strobe_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic [9:0]  pindex_ff, pindex_in;

   logic        accept;
   logic        finish;
   logic [7:0]  rx;
   logic [7:0]  add_a;
   logic [7:0]  add_b;
   logic [9:0]  pay_idx;
   logic [15:0] length_full;

   assign rx     = req_chan.rx_byte;
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign add_a       = sum_a_ff + rx;
   assign add_b       = sum_b_ff + add_a;
   assign pay_idx     = position_ff - POS_AFTER_LENHI;
   assign length_full = {rx, length_ff[7:0]};

   always_comb begin
      phase_in    = phase_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      length_in   = length_ff;
      position_in = position_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      check_a_in  = check_a_ff;
      status_in   = STATUS_BUSY;
      strobe_in   = 1'b0;
      pbyte_in    = 8'd0;
      pindex_in   = 10'd0;
      finish      = 1'b0;

      case (phase_ff)
         PH_HUNT2: begin
            if (rx == SYNC_SECOND) begin
               phase_in    = PH_CLASS;
               position_in = POS_AFTER_SYNC2;
            end else begin
               phase_in    = PH_HUNT1;
               position_in = 10'd0;
            end
         end
         PH_CLASS: begin
            class_in    = rx;
            sum_a_in    = rx;
            sum_b_in    = rx;
            position_in = POS_AFTER_CLASS;
            phase_in    = PH_ID;
         end
         PH_ID: begin
            id_in       = rx;
            sum_a_in    = add_a;
            sum_b_in    = add_b;
            position_in = POS_AFTER_ID;
            phase_in    = PH_LENLO;
         end
         PH_LENLO: begin
            length_in   = {8'd0, rx};
            sum_a_in    = add_a;
            sum_b_in    = add_b;
            position_in = POS_AFTER_LENLO;
            phase_in    = PH_LENHI;
         end
         PH_LENHI: begin
            length_in   = length_full;
            sum_a_in    = add_a;
            sum_b_in    = add_b;
            position_in = POS_AFTER_LENHI;
            phase_in    = (length_full == 16'd0) ? PH_CHKA : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if ({1'b0, position_ff} + 11'd1 >= MaxFrameW) begin
               status_in = STATUS_OVERFLOW;
               finish    = 1'b1;
            end else begin
               strobe_in   = 1'b1;
               pbyte_in    = rx;
               pindex_in   = pay_idx;
               sum_a_in    = add_a;
               sum_b_in    = add_b;
               position_in = position_ff + 10'd1;
               if ({6'd0, pay_idx} + 16'd1 == length_ff) begin
                  phase_in = PH_CHKA;
               end
            end
         end
         PH_CHKA: begin
            check_a_in  = rx;
            position_in = position_ff + 10'd1;
            phase_in    = PH_CHKB;
         end
         PH_CHKB: begin
            status_in = (check_a_ff == sum_a_ff && rx == sum_b_ff) ? STATUS_GOOD : STATUS_BAD;
            finish    = 1'b1;
         end
         default: begin
            class_in    = 8'd0;
            id_in       = 8'd0;
            length_in   = 16'd0;
            sum_a_in    = 8'd0;
            sum_b_in    = 8'd0;
            check_a_in  = 8'd0;
            if (rx == SYNC_FIRST) begin
               phase_in    = PH_HUNT2;
               position_in = POS_AFTER_SYNC1;
            end else begin
               phase_in    = PH_HUNT1;
               position_in = 10'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT1;
         class_ff     <= 8'd0;
         id_ff        <= 8'd0;
         length_ff    <= 16'd0;
         position_ff  <= 10'd0;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
         check_a_ff   <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (finish) begin
               phase_ff    <= PH_HUNT1;
               class_ff    <= 8'd0;
               id_ff       <= 8'd0;
               length_ff   <= 16'd0;
               position_ff <= 10'd0;
               sum_a_ff    <= 8'd0;
               sum_b_ff    <= 8'd0;
               check_a_ff  <= 8'd0;
            end else begin
               phase_ff    <= phase_in;
               class_ff    <= class_in;
               id_ff       <= id_in;
               length_ff   <= length_in;
               position_ff <= position_in;
               sum_a_ff    <= sum_a_in;
               sum_b_ff    <= sum_b_in;
               check_a_ff  <= check_a_in;
            end
            rsp_valid_ff  <= 1'b1;
            status_ff     <= status_in;
            out_class_ff  <= class_in;
            out_id_ff     <= id_in;
            out_length_ff <= length_in;
            strobe_ff     <= strobe_in;
            pbyte_ff      <= pbyte_in;
            pindex_ff     <= pindex_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.frame_class    = out_class_ff;
   assign rsp_chan.frame_id       = out_id_ff;
   assign rsp_chan.frame_length   = out_length_ff;
   assign rsp_chan.payload_strobe = strobe_ff;
   assign rsp_chan.payload_byte   = pbyte_ff;
   assign rsp_chan.payload_index  = pindex_ff;

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && strobe_ff |-> status_ff == STATUS_BUSY)
      else $error("payload strobe with a final status");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("byte taken while a result is stalled");

   a_finish_hunts: assert property (@(posedge clock) disable iff (reset)
      accept && finish |=> phase_ff == PH_HUNT1 && position_ff == 10'd0)
      else $error("parser did not return to hunting after a frame end");

   a_payload_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> position_ff >= POS_AFTER_LENHI && length_ff != 16'd0)
      else $error("payload phase with an impossible frame position");
`endif

endmodule

// ===== rtl/gnss_binary_frame_parser.sv =====
// Binary GNSS frame parser, top level.
// req_chan carries one received serial byte per transaction (valid, ready,
// rx_byte). rsp_chan returns exactly one result transaction per byte:
// status (in progress, frame good, checksum bad, overflow dropped), the
// class, id and length of the current frame, and for payload bytes the
// strobe, the byte and its index within the payload.
// The result is registered at the edge that accepts its byte; throughput is
// one byte per cycle while the receiver takes each result, as the result
// register loads from the same next-state logic as the parser state.
// MAX_FRAME bounds the frame size; a payload byte that brings the frame to
// MAX_FRAME bytes drops the frame with overflow status.
// A synchronous reset returns the parser to hunting for the first sync byte
// and empties the result register.
// When the receiver stalls, the pending result holds and req_chan.ready
// drops; a new byte is taken in the cycle its predecessor's result leaves.
module gnss_binary_frame_parser
   import gbfp_pkg::*;
#(
   parameter int MAX_FRAME = 1022
) (
   input logic        clock,
   input logic        reset,
   gbfp_req_if.sink   req_chan,
   gbfp_rsp_if.source rsp_chan
);

   gbfp_frame_parser #(
      .MAX_FRAME(MAX_FRAME)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
